// ===== design/hysteresis_backpressure_queue_assert.svh =====
// ----------------------------------------------------------------------------
// hysteresis_backpressure_queue_assert.svh
// assertion macros shared by the retry queue modules; empty under synthesis
// ----------------------------------------------------------------------------
`ifndef HYSTERESIS_BACKPRESSURE_QUEUE_ASSERT_SVH
`define HYSTERESIS_BACKPRESSURE_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define HBQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// overlapping implication checked at every clock edge outside reset
`define HBQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked at every clock edge outside reset
`define HBQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HBQ_ASSERT(label, clk, rst_n, prop, msg)
`define HBQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define HBQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/hbq_pkg.sv =====
// ----------------------------------------------------------------------------
// hbq_pkg
// types, widths and codes shared by the retry queue modules
// ----------------------------------------------------------------------------
`default_nettype none

package hbq_pkg;

    // default queue depth
    localparam int QUEUE_DEPTH_DEF = 64;

    // descriptor field widths
    localparam int HANDLE_W = 16;
    localparam int SEQ_W    = 32;
    localparam int CHUNK_W  = 32;
    localparam int ENTRY_W  = HANDLE_W + SEQ_W + CHUNK_W;

    // reported count width
    localparam int COUNT_OUT_W = 7;

    // configuration registers
    localparam int UPPER_W   = 7;
    localparam int LOWER_W   = 6;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 1'b1;
    localparam logic [UPPER_W-1:0]   UPPER_RST = 7'd48;
    localparam logic [LOWER_W-1:0]   LOWER_RST = 6'd16;

    // event kinds
    localparam logic CMD_REFUSED = 1'b0;
    localparam logic CMD_SENT    = 1'b1;

    // source of the emitted descriptor
    localparam int SRC_W = 2;
    localparam logic [SRC_W-1:0] SRC_NONE  = 2'd0;
    localparam logic [SRC_W-1:0] SRC_INPUT = 2'd1;
    localparam logic [SRC_W-1:0] SRC_RAM   = 2'd2;

    // input beat
    typedef struct packed {
        logic                cmd;
        logic [HANDLE_W-1:0] buf_handle;
        logic [SEQ_W-1:0]    seq_num;
        logic [CHUNK_W-1:0]  chunk_num;
    } in_t;

    // output beat
    typedef struct packed {
        logic                   emit_valid;
        logic [HANDLE_W-1:0]    emit_handle;
        logic [SEQ_W-1:0]       emit_seq;
        logic [CHUNK_W-1:0]     emit_chunk;
        logic                   apply_pulse;
        logic                   release_pulse;
        logic                   pressure_on;
        logic [COUNT_OUT_W-1:0] queued_count;
        logic                   dropped;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

// ===== design/hbq_ram.sv =====
// ----------------------------------------------------------------------------
// hbq_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module hbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/hbq_ctrl.sv =====
// ----------------------------------------------------------------------------
// hbq_ctrl
// sequencer for the retry queue: accept, execute, load result
// ----------------------------------------------------------------------------
`default_nettype none

`include "hysteresis_backpressure_queue_assert.svh"

module hbq_ctrl
    import hbq_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire ctrl_status_t status,
    output ctrl_cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // input is taken while idle or while the previous result is loaded
    assign in_stall = !((state_reg == ST_IDLE) || (state_reg == ST_LOAD));

    // commands to the datapath
    always_comb
    begin
        cmd.capture = in_valid && !in_stall;
        cmd.exec    = (state_reg == ST_EXEC) && status.out_free;
        cmd.load    = (state_reg == ST_LOAD);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = in_valid ? ST_EXEC : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // every execute step is followed by a load
    `HBQ_ASSERT_NXT(a_exec_then_load, clk, rst_n, cmd.exec, cmd.load,
        "exec not followed by load")

    // only the three defined state codes appear
    `HBQ_ASSERT(a_state_legal, clk, rst_n,
        (state_reg == ST_IDLE) || (state_reg == ST_EXEC) || (state_reg == ST_LOAD),
        "illegal sequencer state")

    // an accepted beat always moves on to execute
    `HBQ_ASSERT_NXT(a_capture_exec, clk, rst_n, cmd.capture, state_reg == ST_EXEC,
        "accepted beat not executed")

endmodule

`default_nettype wire

// ===== design/hbq_dp.sv =====
// ----------------------------------------------------------------------------
// hbq_dp
// retry queue datapath: descriptor ring, pending slot, thresholds, result reg
// ----------------------------------------------------------------------------
`default_nettype none

`include "hysteresis_backpressure_queue_assert.svh"

module hbq_dp
    import hbq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctrl_cmd_t            cmd,
    output ctrl_status_t              status,
    input  wire in_t                  in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_t                      out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > UPPER_W) ? CNT_W : UPPER_W;

    in_t                    in_reg;
    logic [PTR_W-1:0]       head_reg;
    logic [PTR_W-1:0]       head_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   pend_valid_reg;
    logic                   pend_valid_next;
    logic [SEQ_W-1:0]       pend_seq_reg;
    logic [CHUNK_W-1:0]     pend_chunk_reg;
    logic                   pressure_reg;
    logic                   pressure_next;
    logic [UPPER_W-1:0]     upper_reg;
    logic [LOWER_W-1:0]     lower_reg;
    logic [SRC_W-1:0]       src_reg;
    logic [SRC_W-1:0]       src_next;
    logic                   apply_reg;
    logic                   apply_next;
    logic                   release_reg;
    logic                   release_next;
    logic                   drop_reg;
    logic                   drop_next;
    logic                   pend_ram_reg;
    logic                   pend_ram_next;
    logic                   pend_in_next;
    logic                   out_valid_reg;
    out_t                   out_data_reg;

    logic                   match;
    logic                   push;
    logic                   pop;
    logic [CNT_W-1:0]       count_push;
    logic [SUM_W-1:0]       tail_sum;
    logic [PTR_W-1:0]       tail_ptr;
    logic [PTR_W-1:0]       head_inc;
    logic [ENTRY_W-1:0]     ram_rd_data;
    logic [HANDLE_W-1:0]    emit_handle;
    logic [SEQ_W-1:0]       emit_seq;
    logic [CHUNK_W-1:0]     emit_chunk;

    // ring pointers
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_ptr = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
    assign head_inc = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // retry match against the pending slot
    assign match = pend_valid_reg && (in_reg.seq_num == pend_seq_reg)
                   && (in_reg.chunk_num == pend_chunk_reg);

    // event decision
    always_comb
    begin
        push          = 1'b0;
        pop           = 1'b0;
        count_push    = count_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        pend_valid_next = pend_valid_reg;
        pend_in_next  = 1'b0;
        pend_ram_next = 1'b0;
        pressure_next = pressure_reg;
        apply_next    = 1'b0;
        release_next  = 1'b0;
        drop_next     = 1'b0;
        src_next      = SRC_NONE;
        if (in_reg.cmd == CMD_REFUSED)
        begin
            if (match)
            begin
                src_next = SRC_INPUT;
            end
            else
            begin
                push       = (count_reg != CNT_W'(QUEUE_DEPTH));
                drop_next  = !push;
                count_push = count_reg + CNT_W'(push);
                if (!pressure_reg && (CMP_W'(count_push) >= CMP_W'(upper_reg)))
                begin
                    pressure_next = 1'b1;
                    apply_next    = 1'b1;
                end
                if (!pend_valid_reg && (count_push != '0))
                begin
                    pend_valid_next = 1'b1;
                    // an empty queue hands the pushed descriptor straight back
                    if (count_reg == '0)
                    begin
                        src_next     = SRC_INPUT;
                        pend_in_next = 1'b1;
                    end
                    else
                    begin
                        pop           = 1'b1;
                        src_next      = SRC_RAM;
                        pend_ram_next = 1'b1;
                    end
                    head_next = head_inc;
                end
                count_next = (pend_valid_next && !pend_valid_reg) ?
                             count_push - 1'b1 : count_push;
            end
        end
        else
        begin
            pend_valid_next = 1'b0;
            if (pressure_reg && (CMP_W'(count_reg) <= CMP_W'(lower_reg)))
            begin
                pressure_next = 1'b0;
                release_next  = 1'b1;
            end
            if (count_reg != '0)
            begin
                pop        = 1'b1;
                src_next   = SRC_RAM;
                head_next  = head_inc;
                count_next = count_reg - 1'b1;
            end
        end
    end

    // descriptor ring
    hbq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.exec && push),
        .wr_addr (tail_ptr),
        .wr_data ({in_reg.buf_handle, in_reg.seq_num, in_reg.chunk_num}),
        .rd_en   (cmd.exec && pop),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    // emitted descriptor
    always_comb
    begin
        emit_handle = '0;
        emit_seq    = '0;
        emit_chunk  = '0;
        case (src_reg)
            SRC_INPUT:
            begin
                emit_handle = in_reg.buf_handle;
                emit_seq    = in_reg.seq_num;
                emit_chunk  = in_reg.chunk_num;
            end
            SRC_RAM:
            begin
                {emit_handle, emit_seq, emit_chunk} = ram_rd_data;
            end
            default:
            begin
                emit_handle = '0;
            end
        endcase
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= in_data;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= UPPER_RST;
            lower_reg <= LOWER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_UPPER: upper_reg <= cfg_wdata[UPPER_W-1:0];
                CFG_LOWER: lower_reg <= cfg_wdata[LOWER_W-1:0];
                default:   upper_reg <= upper_reg;
            endcase
        end
    end

    // queue and pending state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_seq_reg   <= '0;
            pend_chunk_reg <= '0;
            pressure_reg   <= 1'b0;
            src_reg        <= SRC_NONE;
            apply_reg      <= 1'b0;
            release_reg    <= 1'b0;
            drop_reg       <= 1'b0;
            pend_ram_reg   <= 1'b0;
        end
        else if (cmd.exec)
        begin
            head_reg       <= head_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            pressure_reg   <= pressure_next;
            src_reg        <= src_next;
            apply_reg      <= apply_next;
            release_reg    <= release_next;
            drop_reg       <= drop_next;
            pend_ram_reg   <= pend_ram_next;
            if (pend_in_next)
            begin
                pend_seq_reg   <= in_reg.seq_num;
                pend_chunk_reg <= in_reg.chunk_num;
            end
            else if (!pend_valid_next)
            begin
                pend_seq_reg   <= '0;
                pend_chunk_reg <= '0;
            end
        end
        else if (cmd.load && pend_ram_reg)
        begin
            // popped head becomes the pending retry once read back
            pend_seq_reg   <= emit_seq;
            pend_chunk_reg <= emit_chunk;
            pend_ram_reg   <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_data_reg.emit_valid    <= (src_reg != SRC_NONE);
            out_data_reg.emit_handle   <= emit_handle;
            out_data_reg.emit_seq      <= emit_seq;
            out_data_reg.emit_chunk    <= emit_chunk;
            out_data_reg.apply_pulse   <= apply_reg;
            out_data_reg.release_pulse <= release_reg;
            out_data_reg.pressure_on   <= pressure_reg;
            out_data_reg.queued_count  <= COUNT_OUT_W'(count_reg);
            out_data_reg.dropped       <= drop_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

    // checks
    `HBQ_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(QUEUE_DEPTH),
        "count above depth")
    `HBQ_ASSERT_IMP(a_load_free, clk, rst_n, cmd.load, !out_valid_reg,
        "result reg overwritten")
    `HBQ_ASSERT_IMP(a_pressure_rise, clk, rst_n, $rose(pressure_reg),
        $past(cmd.exec) && $past(apply_next), "pressure rose without apply")

endmodule

`default_nettype wire

// ===== design/hysteresis_backpressure_queue.sv =====
// ----------------------------------------------------------------------------
// hysteresis_backpressure_queue
// retry queue for refused buffer descriptors with hysteresis backpressure
// ----------------------------------------------------------------------------
// Each event is first executed when the output is free (compare with the
// pending slot, push at the tail, issue the head read), and its result is
// then loaded while the next event is accepted. This split is set by the
// registered read of the single descriptor ram, whose head entry is only
// available the cycle after it is addressed. A stalled output holds the next
// event in execute until the result register drains.
// The queue holds QUEUE_DEPTH descriptors and needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module hysteresis_backpressure_queue
    import hbq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_t                  in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_t                      out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // sequencer
    hbq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    hbq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

`default_nettype wire
